FILE: sv/hne_pkg.sv
// ============================================================================
// hne_pkg
// Shared types, codes and helpers of the hex number entry editor.
// ============================================================================
package hne_pkg;

    // input item kinds
    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_START  = 2'd1;
    localparam logic [1:0] KIND_PRESET = 2'd2;

    // default digit limit
    localparam int MAX_DIGITS_DEF = 4;

    // job queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // terminal characters
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        ST_CONTINUE = 3'd0,
        ST_NEXT     = 3'd1,
        ST_FINISH   = 3'd2,
        ST_DELETE   = 3'd3,
        ST_CANCEL   = 3'd4
    } t_status;

    // echo sequencer phases; PH_START marks "no job begun yet" and "job done"
    typedef enum logic [2:0] {
        PH_START,
        PH_ERASE,
        PH_SHOW,
        PH_TAIL,
        PH_CR,
        PH_LF,
        PH_NONE
    } t_phase;

    // one classified item, as handed from front to back
    typedef struct packed {
        logic [2:0]  erase_n;    // backspace-space-backspace groups
        logic [2:0]  show_n;     // hex digits of value to show, MSB first
        logic        has_tail;   // echo tail_char after the digits
        logic        crlf;       // CR LF after the tail
        logic [7:0]  tail_char;
        t_status     status;
        logic [15:0] value;      // entry value after the item
    } t_job;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = 8'h30 + {4'h0, d};
        end else begin
            r = 8'h37 + {4'h0, d};
        end
        return r;
    endfunction

    // returns {is_hex, digit}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    // phase that follows ph within a job; PH_START means the job is done
    function automatic t_phase after_phase(input t_job j, input t_phase ph);
        t_phase r;
        r = PH_START;
        case (ph)
            PH_ERASE: r = (j.show_n != 3'd0) ? PH_SHOW : (j.has_tail ? PH_TAIL : PH_START);
            PH_SHOW:  r = j.has_tail ? PH_TAIL : PH_START;
            PH_TAIL:  r = j.crlf ? PH_CR : PH_START;
            PH_CR:    r = PH_LF;
            default:  r = PH_START;
        endcase
        return r;
    endfunction

    function automatic t_phase first_phase(input t_job j);
        t_phase r;
        if (j.erase_n != 3'd0) begin
            r = PH_ERASE;
        end else if (j.show_n != 3'd0) begin
            r = PH_SHOW;
        end else if (j.has_tail) begin
            r = PH_TAIL;
        end else begin
            r = PH_NONE;
        end
        return r;
    endfunction

endpackage

FILE: sv/hne_front.sv
// ============================================================================
// hne_front
// Takes input items, updates the entry state and classifies each item into
// an echo job for the back end.
// ============================================================================
module hne_front
    import hne_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic        i_wide_entry,
    input  logic [15:0] i_preset_value,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    localparam logic [2:0] WIDE_W   = 3'((MAX_DIGITS < 4) ? MAX_DIGITS : 4);
    localparam logic [2:0] NARROW_W = 3'((MAX_DIGITS < 2) ? MAX_DIGITS : 2);

    logic [15:0] r_acc, n_acc;
    logic [2:0]  r_typed, n_typed;
    logic [2:0]  r_width, n_width;

    logic [4:0]  hv;
    logic [2:0]  start_w;
    logic [15:0] preset_mask;
    logic        is_white;
    t_job        job;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign o_job   = job;

    always_comb begin
        hv       = hex_value(i_char_code);
        start_w  = i_wide_entry ? WIDE_W : NARROW_W;
        is_white = (i_char_code == CH_SP) ||
                   (i_char_code >= CH_TAB && i_char_code <= CH_CR);
        case (start_w)
            3'd1:    preset_mask = 16'h000F;
            3'd2:    preset_mask = 16'h00FF;
            3'd3:    preset_mask = 16'h0FFF;
            default: preset_mask = 16'hFFFF;
        endcase

        n_acc   = r_acc;
        n_typed = r_typed;
        n_width = r_width;
        job     = '0;
        job.status = ST_CONTINUE;

        unique case (i_kind)
            KIND_START: begin
                n_width = start_w;
                n_typed = 3'd0;
                n_acc   = 16'h0000;
            end
            KIND_PRESET: begin
                n_width     = start_w;
                n_typed     = start_w;
                n_acc       = i_preset_value & preset_mask;
                job.erase_n = start_w;
                job.show_n  = start_w;
            end
            KIND_CHAR: begin
                if (hv[4] && r_typed < r_width) begin
                    n_acc      = {r_acc[11:0], hv[3:0]};
                    n_typed    = r_typed + 3'd1;
                    job.show_n = 3'd1;  // low nibble is the new digit
                end else if (i_char_code == CH_BS || i_char_code == CH_DEL) begin
                    if (r_typed == 3'd0) begin
                        job.status = ST_DELETE;
                    end else begin
                        job.erase_n = 3'd1;
                        n_acc       = {4'h0, r_acc[15:4]};
                        n_typed     = r_typed - 3'd1;
                    end
                end else if (r_typed != 3'd0 && is_white) begin
                    job.erase_n   = r_typed;
                    job.show_n    = r_width;
                    job.has_tail  = 1'b1;
                    job.tail_char = i_char_code;
                    n_typed       = r_width;
                    if (i_char_code == CH_SP) begin
                        job.status = ST_NEXT;
                    end else begin
                        job.crlf   = 1'b1;
                        job.status = ST_FINISH;
                    end
                end else if (i_char_code == CH_ESC) begin
                    job.status = ST_CANCEL;
                end
            end
            default: begin
            end
        endcase
        job.value = n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 16'h0000;
            r_typed <= 3'd0;
            r_width <= WIDE_W;
        end else if (o_push) begin
            r_acc   <= n_acc;
            r_typed <= n_typed;
            r_width <= n_width;
        end
    end

endmodule

FILE: sv/hne_queue.sv
// ============================================================================
// hne_queue
// Short job queue between front and back.
// ============================================================================
module hne_queue
    import hne_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == LAST_P) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == LAST_P) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/hne_back.sv
// ============================================================================
// hne_back
// Echo sequencer: walks the head job and emits one result per cycle into
// the output register while the receiver does not stall.
// ============================================================================
module hne_back
    import hne_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_echo_char,
    output logic        o_echo_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_entry_value,
    output logic        o_last
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_cnt, n_cnt;
    logic [1:0]  r_sub, n_sub;

    t_phase      ph, nxt_ph;
    logic        adv, emit, ph_end, last;
    logic [7:0]  ch;
    logic        ev;
    logic [2:0]  idx;
    logic [15:0] shifted;

    assign adv  = !o_valid || !i_stall;
    assign emit = adv && !i_empty;

    always_comb begin
        ph      = (r_phase == PH_START) ? first_phase(i_head) : r_phase;
        ch      = CH_NUL;
        ev      = 1'b1;
        ph_end  = 1'b0;
        idx     = i_head.show_n - 3'd1 - r_cnt;
        shifted = i_head.value >> {idx[1:0], 2'b00};
        unique case (ph)
            PH_ERASE: begin
                ch     = (r_sub == 2'd1) ? CH_SP : CH_BS;
                ph_end = (r_sub == 2'd2) && (r_cnt == i_head.erase_n - 3'd1);
            end
            PH_SHOW: begin
                ch     = hex_char(shifted[3:0]);
                ph_end = (r_cnt == i_head.show_n - 3'd1);
            end
            PH_TAIL: begin
                ch     = i_head.tail_char;
                ph_end = 1'b1;
            end
            PH_CR: begin
                ch     = CH_CR;
                ph_end = 1'b1;
            end
            PH_LF: begin
                ch     = CH_LF;
                ph_end = 1'b1;
            end
            default: begin
                ev     = 1'b0;
                ph_end = 1'b1;
            end
        endcase
        nxt_ph = after_phase(i_head, ph);
        last   = ph_end && (nxt_ph == PH_START);

        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_sub   = r_sub;
        if (emit) begin
            if (ph_end) begin
                n_phase = nxt_ph;
                n_cnt   = 3'd0;
                n_sub   = 2'd0;
            end else begin
                n_phase = ph;
                if (ph == PH_ERASE) begin
                    if (r_sub == 2'd2) begin
                        n_sub = 2'd0;
                        n_cnt = r_cnt + 3'd1;
                    end else begin
                        n_sub = r_sub + 2'd1;
                    end
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
        end
    end

    assign o_pop = emit && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_cnt   <= 3'd0;
            r_sub   <= 2'd0;
            o_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_sub   <= n_sub;
            if (adv) begin
                o_valid <= !i_empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_echo_char   <= ch;
            o_echo_valid  <= ev;
            o_status      <= i_head.status;
            o_entry_value <= i_head.value;
            o_last        <= last;
        end
    end

endmodule

FILE: sv/hex_number_entry_editor_core.sv
// ============================================================================
// hex_number_entry_editor_core
// Hex number entry line editor: terminal characters in, echo stream and
// entry status out.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item per handshake:
//   a character, a start of an empty entry, or a start with a preset value.
//   Output channel (o_out_valid / i_out_stall) carries the results of each
//   item, one echo character per result, o_last set on the final one. An
//   item with nothing to echo gives one result with o_echo_valid low.
//   Every result carries the item's status and the entry value after it.
//   The first result of an item passes through the job queue and the output
//   register. Throughput: one result per cycle out of the echo sequencer
//   while the receiver does not stall; an item has 1 to 19 results
//   (a whitespace on a full four-digit entry is 4 erase groups, 4 digits,
//   the whitespace and CR LF). The front takes a new item every cycle while
//   the two-entry job queue has room.
//   Reset (synchronous, active low) clears the queue and the output and sets
//   an empty four-digit entry.
//   When the receiver stalls, the output register holds its result; the
//   queue fills and o_in_stall rises once it is full.
module hex_number_entry_editor_core
    import hne_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_char_code,
    input  logic        i_wide_entry,
    input  logic [15:0] i_preset_value,
    // results
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_echo_char,
    output logic        o_echo_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_entry_value,
    output logic        o_last
);

    // front to queue
    logic q_push;
    t_job q_job;
    logic q_full;
    // queue to back
    logic q_pop;
    logic q_empty;
    t_job q_head;

    // Front: holds the entry state and turns each item into an echo job.
    hne_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_kind         (i_kind),
        .i_char_code    (i_char_code),
        .i_wide_entry   (i_wide_entry),
        .i_preset_value (i_preset_value),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_job          (q_job)
    );

    // Decouples item intake from the multi-cycle echo.
    hne_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Back: phase sequencer (erase, digits, tail, CR, LF) into output reg.
    hne_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (q_empty),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .o_valid       (o_out_valid),
        .i_stall       (i_out_stall),
        .o_echo_char   (o_echo_char),
        .o_echo_valid  (o_echo_valid),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_last        (o_last)
    );

    // A result without a character is always the only, hence last, one.
    a_noecho_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_echo_valid) |-> (o_last && o_echo_char == CH_NUL))
        else $error("no-echo result not last or carries a character");

    // Delete and cancel never echo.
    a_quiet_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_DELETE || o_status == ST_CANCEL))
            |-> !o_echo_valid)
        else $error("delete or cancel echoed a character");

    // A finish ends with LF, a next ends with the space.
    a_finish_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last && o_status == ST_FINISH) |-> (o_echo_char == CH_LF))
        else $error("finish not closed by LF");

    a_next_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last && o_status == ST_NEXT) |-> (o_echo_char == CH_SP))
        else $error("next not closed by space");

endmodule

FILE: dv/tb_top.sv
// ============================================================================
// tb_top
// Testbench of hex_number_entry_editor_core. Drives characters, empty starts
// and preset loads through the valid/stall input channel. A built-in entry
// model predicts every echo result, and each result taken from the output
// channel is checked against it. The input idles and the output stalls at random.
// ============================================================================
module tb_top;
    import hne_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // kind code that the block does not use
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int DIGITS = MAX_DIGITS_DEF;
    localparam int ITEM_TARGET = 360;
    // a single item can emit up to 19 results; enough to let the last ones drain
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX = 10;

    // one echo result as seen on the output ports
    typedef struct packed {
        logic [7:0]  echo_char;
        logic        echo_valid;
        t_status     status;
        logic [15:0] value;
        logic        last;
    } echo_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind = KIND_CHAR;
    logic [7:0]  i_char_code = CH_NUL;
    logic        i_wide_entry = 1'b0;
    logic [15:0] i_preset_value = 16'h0000;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_echo_char;
    logic        o_echo_valid;
    logic [2:0]  o_status;
    logic [15:0] o_entry_value;
    logic        o_last;

    // entry state as the model sees it: value, digits typed, digit width
    logic [15:0] m_value = 16'h0000;
    logic [2:0]  m_typed = 3'd0;
    logic [2:0]  m_width = 3'(DIGITS);

    logic [7:0]  line_chars[$];   // echo characters of the item being predicted
    echo_t       echo_q[$];       // results still owed by the block

    // whitespace that closes an entry: TAB, LF, VT, FF, CR, space
    logic [7:0]  blanks[6] = '{CH_TAB, CH_LF, 8'h0B, 8'h0C, CH_CR, CH_SP};

    int n_items = 0;
    int n_results = 0;
    int n_errors = 0;
    int burst_left = 0;
    int status_seen[5] = '{0, 0, 0, 0, 0};

    hex_number_entry_editor_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_char_code    (i_char_code),
        .i_wide_entry   (i_wide_entry),
        .i_preset_value (i_preset_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_echo_char    (o_echo_char),
        .o_echo_valid   (o_echo_valid),
        .o_status       (o_status),
        .o_entry_value  (o_entry_value),
        .o_last         (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Entry model
    // ------------------------------------------------------------------------
    function automatic logic [2:0] entry_width(input logic wide);
        int w;
        w = wide ? 4 : 2;
        if (w > DIGITS) begin
            w = DIGITS;
        end
        return 3'(w);
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] d);
        return (d < 4'd10) ? "0" + 8'(d) : "A" + 8'(d) - 8'd10;
    endfunction

    // hex digit value of a character, -1 if it is not a hex digit
    function automatic int char_digit(input logic [7:0] c);
        int d;
        d = -1;
        if (c >= "0" && c <= "9") begin
            d = int'(c - "0");
        end else if (c >= "A" && c <= "F") begin
            d = int'(c - "A") + 10;
        end else if (c >= "a" && c <= "f") begin
            d = int'(c - "a") + 10;
        end
        return d;
    endfunction

    // backspace, space, backspace for each digit wiped off the screen
    function automatic void push_erase(input int n);
        repeat (n) begin
            line_chars.push_back(CH_BS);
            line_chars.push_back(CH_SP);
            line_chars.push_back(CH_BS);
        end
    endfunction

    // whole entry, zero padded to the digit width, most significant first
    function automatic void push_value();
        for (int i = int'(m_width); i > 0; i--) begin
            line_chars.push_back(nibble_char(m_value[4 * (i - 1) +: 4]));
        end
    endfunction

    // Updates the entry state for one accepted item and queues its results.
    function automatic void predict_echo(input logic [1:0] kind, input logic [7:0] ch,
                                         input logic wide, input logic [15:0] preset);
        t_status st;
        int      dig;
        echo_t   r;
        st = ST_CONTINUE;
        line_chars.delete();
        case (kind)
            KIND_START: begin
                m_width = entry_width(wide);
                m_typed = 3'd0;
                m_value = 16'h0000;
            end
            KIND_PRESET: begin
                m_width = entry_width(wide);
                push_erase(int'(m_width));
                // preset wider than the entry keeps only its low digits
                m_value = preset & 16'((32'd1 << (4 * m_width)) - 32'd1);
                m_typed = m_width;
                push_value();
            end
            KIND_CHAR: begin
                dig = char_digit(ch);
                if (dig >= 0 && m_typed < m_width) begin
                    line_chars.push_back(nibble_char(4'(dig)));
                    m_typed = m_typed + 3'd1;
                    m_value = {m_value[11:0], 4'(dig)};
                end else if (ch == CH_BS || ch == CH_DEL) begin
                    if (m_typed == 3'd0) begin
                        st = ST_DELETE;
                    end else begin
                        push_erase(1);
                        m_value = m_value >> 4;
                        m_typed = m_typed - 3'd1;
                    end
                end else if (m_typed != 3'd0 &&
                             (ch == CH_SP || (ch >= CH_TAB && ch <= CH_CR))) begin
                    // rewrite the entry padded, then echo the whitespace itself
                    push_erase(int'(m_typed));
                    m_typed = m_width;
                    push_value();
                    line_chars.push_back(ch);
                    if (ch == CH_SP) begin
                        st = ST_NEXT;
                    end else begin
                        line_chars.push_back(CH_CR);
                        line_chars.push_back(CH_LF);
                        st = ST_FINISH;
                    end
                end else if (ch == CH_ESC) begin
                    st = ST_CANCEL;
                end
            end
            default: begin
            end
        endcase

        r.status = st;
        r.value  = m_value;
        if (line_chars.size() == 0) begin
            r.echo_char  = CH_NUL;
            r.echo_valid = 1'b0;
            r.last       = 1'b1;
            echo_q.push_back(r);
        end else begin
            foreach (line_chars[i]) begin
                r.echo_char  = line_chars[i];
                r.echo_valid = 1'b1;
                r.last       = (i == line_chars.size() - 1);
                echo_q.push_back(r);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side: bursts of items with random gaps between them
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] kind, input logic [7:0] ch,
                             input logic wide, input logic [15:0] preset);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 25)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid     <= 1'b1;
        i_kind         <= kind;
        i_char_code    <= ch;
        i_wide_entry   <= wide;
        i_preset_value <= preset;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_echo(kind, ch, wide, preset);
        n_items++;
    endtask

    function automatic logic [7:0] random_hex_char();
        int d;
        d = $urandom_range(0, 15);
        if (d < 10) begin
            return "0" + 8'(d);
        end
        return ($urandom_range(0, 1) ? "a" : "A") + 8'(d - 10);
    endfunction

    function automatic logic [7:0] random_blank();
        return blanks[$urandom_range(0, 5)];
    endfunction

    function automatic logic [7:0] random_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic random_wide();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [15:0] random_preset();
        return 16'($urandom_range(0, 65535));
    endfunction

    // ------------------------------------------------------------------------
    // Output side: stall pattern in segments of no, light and heavy stalling
    // ------------------------------------------------------------------------
    initial begin : out_stall_pattern
        int mode;
        int seg;
        forever begin
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(20, 150);
            repeat (seg) begin
                @(posedge i_clk);
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 2) == 0);
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic void flag_error(input string msg);
        n_errors++;
        if (n_errors <= REPORT_MAX) begin
            $display("%s", msg);
        end
    endfunction

    // every result taken is checked against the oldest one still owed
    always @(posedge i_clk) begin : result_check
        echo_t got;
        echo_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_echo_char, o_echo_valid, t_status'(o_status), o_entry_value, o_last};
            n_results++;
            if (echo_q.size() == 0) begin
                flag_error($sformatf(
                    "unexpected result: char %h valid %b status %0d value %h last %b",
                    got.echo_char, got.echo_valid, got.status, got.value, got.last));
            end else begin
                want = echo_q.pop_front();
                if (got !== want) begin
                    flag_error($sformatf({"result %0d mismatch: char %h/%h valid %b/%b ",
                        "status %0d/%0d value %h/%h last %b/%b (exp/got)"},
                        n_results, want.echo_char, got.echo_char, want.echo_valid,
                        got.echo_valid, want.status, got.status, want.value, got.value,
                        want.last, got.last));
                end
                if (want.last && int'(want.status) < 5) begin
                    status_seen[int'(want.status)]++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_top: timeout with %0d results outstanding", echo_q.size());
        $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // entry after reset is an empty four-digit one; close it with a tab
    task automatic test_reset_entry();
        send_item(KIND_CHAR, "9", 1'b0, 16'h0000);
        send_item(KIND_CHAR, CH_TAB, 1'b0, 16'h0000);
    endtask

    // two-digit entry: case folding, full entry, deletes, blank on empty, next
    task automatic test_narrow_entry();
        send_item(KIND_START, CH_NUL, 1'b0, 16'hFFFF);
        send_item(KIND_CHAR, "a", 1'b0, 16'h0000);
        send_item(KIND_CHAR, "F", 1'b0, 16'h0000);
        send_item(KIND_CHAR, "3", 1'b0, 16'h0000);
        send_item(KIND_CHAR, CH_BS, 1'b0, 16'h0000);
        send_item(KIND_CHAR, CH_DEL, 1'b0, 16'h0000);
        send_item(KIND_CHAR, CH_DEL, 1'b0, 16'h0000);
        send_item(KIND_CHAR, CH_SP, 1'b0, 16'h0000);
        send_item(KIND_CHAR, "f", 1'b0, 16'h0000);
        send_item(KIND_CHAR, CH_SP, 1'b0, 16'h0000);
    endtask

    // preset loads, wide and masked to narrow, then close a full entry with CR
    task automatic test_preset_load();
        send_item(KIND_PRESET, 8'hFF, 1'b1, 16'hFFFF);
        send_item(KIND_PRESET, CH_NUL, 1'b0, 16'hABCD);
        send_item(KIND_CHAR, "1", 1'b0, 16'h0000);
        send_item(KIND_CHAR, CH_CR, 1'b0, 16'h0000);
    endtask

    // escape, high codes, NUL, the unused kind and a non-hex letter
    task automatic test_ignored_codes();
        send_item(KIND_CHAR, CH_ESC, 1'b1, 16'h0000);
        send_item(KIND_CHAR, 8'hFF, 1'b1, 16'hFFFF);
        send_item(KIND_CHAR, 8'h80, 1'b0, 16'h0000);
        send_item(KIND_CHAR, CH_NUL, 1'b0, 16'h0000);
        send_item(KIND_UNUSED, 8'hFF, 1'b1, 16'hFFFF);
        send_item(KIND_CHAR, "G", 1'b0, 16'h0000);
    endtask

    // mostly well-formed entries with random digits, some deletes and noise
    task automatic test_random_entries();
        int n_keys;
        while (n_items < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0, 1: send_item(KIND_PRESET, random_byte(), random_wide(), random_preset());
                2, 3, 4, 5, 6: send_item(KIND_START, random_byte(), random_wide(),
                                         random_preset());
                7: send_item(2'($urandom_range(0, 3)), random_byte(), random_wide(),
                             random_preset());
                default: begin
                    // keep typing on whatever entry is open
                end
            endcase
            n_keys = $urandom_range(0, 6);
            repeat (n_keys) begin
                case ($urandom_range(0, 7))
                    0: send_item(KIND_CHAR, $urandom_range(0, 1) ? CH_BS : CH_DEL,
                                 random_wide(), random_preset());
                    1: send_item(KIND_CHAR, random_byte(), random_wide(), random_preset());
                    default: send_item(KIND_CHAR, random_hex_char(), random_wide(),
                                       random_preset());
                endcase
            end
            case ($urandom_range(0, 7))
                0: send_item(KIND_CHAR, CH_ESC, random_wide(), random_preset());
                1: begin
                    // leave the entry open for the next start
                end
                default: send_item(KIND_CHAR, random_blank(), random_wide(), random_preset());
            endcase
        end
    endtask

    initial begin : main
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_entry();
        test_narrow_entry();
        test_preset_load();
        test_ignored_codes();
        test_random_entries();

        i_in_valid <= 1'b0;
        while (echo_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d items sent, %0d echo results checked, %0d mismatches",
                 n_items, n_results, n_errors);
        $display("tb_top: entries ended by next %0d, finish %0d, cancel %0d; empty deletes %0d",
                 status_seen[ST_NEXT], status_seen[ST_FINISH], status_seen[ST_CANCEL],
                 status_seen[ST_DELETE]);
        if (n_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

FILE: hex_number_entry_editor_core.f
sv/hne_pkg.sv
sv/hne_front.sv
sv/hne_queue.sv
sv/hne_back.sv
sv/hex_number_entry_editor_core.sv
dv/tb_top.sv
